[rtl/deq_pkg.sv]
// types, codes and defaults shared by the double-ended queue
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	localparam int DEQ_CAPACITY  = 64;
	localparam int DEQ_WORD_BITS = 32;
	localparam int GROUP_CELLS   = 8;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
	localparam logic [2:0] OP_PEEK_BACK  = 3'd5;
	localparam logic [2:0] OP_CLEAR      = 3'd6;

	localparam logic [1:0] STS_DONE  = 2'd0;
	localparam logic [1:0] STS_DATA  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] item_value;
	} deq_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_value;
		logic [6:0]  occupancy;
	} deq_out_t;

	typedef struct packed {
		logic shift_right;
		logic shift_left;
		logic push_back;
		logic pop_back;
		logic clear;
	} deq_cmd_t;

endpackage
`default_nettype wire

[rtl/deq_cell.sv]
// one entry of the queue: word, valid bit and neighbour shifting
`timescale 1ns / 1ps
`default_nettype none
module deq_cell
	import deq_pkg::*;
#(
	parameter int WORD_BITS = DEQ_WORD_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire deq_cmd_t             cmd,
	input  wire logic [WORD_BITS-1:0] push_word,
	input  wire logic [WORD_BITS-1:0] left_word,
	input  wire logic                 left_valid,
	input  wire logic [WORD_BITS-1:0] right_word,
	input  wire logic                 right_valid,
	output logic      [WORD_BITS-1:0] word,
	output logic                      valid,
	output logic      [WORD_BITS-1:0] back_word
);

	logic [WORD_BITS-1:0] word_q;
	logic                 valid_q;
	logic                 valid_next;
	logic                 is_back;
	logic                 take_push;

	assign is_back   = valid_q && !right_valid;
	assign take_push = cmd.push_back && !valid_q && left_valid;

	always_comb begin
		valid_next = valid_q;
		if (cmd.clear) begin
			valid_next = 1'b0;
		end else if (cmd.shift_right) begin
			valid_next = left_valid;
		end else if (cmd.shift_left) begin
			valid_next = right_valid;
		end else if (take_push) begin
			valid_next = 1'b1;
		end else if (cmd.pop_back && is_back) begin
			valid_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift_right) begin
			word_q <= left_word;
		end else if (cmd.shift_left) begin
			word_q <= right_word;
		end else if (take_push) begin
			word_q <= push_word;
		end
	end

	assign word      = word_q;
	assign valid     = valid_q;
	assign back_word = is_back ? word_q : '0;

endmodule
`default_nettype wire

[rtl/double_ended_queue.sv]
// double-ended queue built as a shifting row of entry cells
//
//  channel   ports                    handshake
//  request   start, busy, request     taken when start is high and busy is low
//  result    done, result             one result per item, marked by done
//
// for each item, the accepting edge also registers the per-group reduction of
// the back entry, and the execute edge acts on the cell row and registers the
// result. done is high in the cycle after that edge, and a new item may be
// taken in that same cycle. the front entry always sits in cell 0, the back
// entry is the last valid cell. reset clears the valid bits and the count, no
// clearing pass. the receiver cannot stall: each result is shown for exactly
// one cycle.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int CAPACITY  = DEQ_CAPACITY,
	parameter int WORD_BITS = DEQ_WORD_BITS
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire deq_in_t request,
	output logic         done,
	output deq_out_t     result
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int GROUPS = (CAPACITY + GROUP_CELLS - 1) / GROUP_CELLS;

	localparam logic PH_IDLE = 1'b0;
	localparam logic PH_EXEC = 1'b1;

	logic                 phase_q;
	logic [2:0]           op_q;
	logic [WORD_BITS-1:0] push_word_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_next;
	logic                 done_q;
	deq_out_t             result_q;
	deq_cmd_t             cmd;
	logic [1:0]           status_c;
	logic [WORD_BITS-1:0] value_c;
	logic                 accept;
	logic                 empty;
	logic                 full;

	logic [WORD_BITS-1:0] cell_word [CAPACITY];
	logic [CAPACITY-1:0]  cell_valid;
	logic [WORD_BITS-1:0] sel_word  [CAPACITY];
	logic [WORD_BITS-1:0] group_or  [GROUPS];
	logic [WORD_BITS-1:0] group_s1  [GROUPS];
	logic [WORD_BITS-1:0] back_word;

	assign accept = start && !busy;
	assign busy   = (phase_q == PH_EXEC);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CNT_W'(CAPACITY));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] lw;
		logic                 lv;
		logic [WORD_BITS-1:0] rw;
		logic                 rv;
		if (i == 0) begin : g_first
			assign lw = push_word_q;
			assign lv = 1'b1;
		end else begin : g_mid
			assign lw = cell_word[i-1];
			assign lv = cell_valid[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rw = '0;
			assign rv = 1'b0;
		end else begin : g_inner
			assign rw = cell_word[i+1];
			assign rv = cell_valid[i+1];
		end
		deq_cell #(
			.WORD_BITS(WORD_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_word  (push_word_q),
			.left_word  (lw),
			.left_valid (lv),
			.right_word (rw),
			.right_valid(rv),
			.word       (cell_word[i]),
			.valid      (cell_valid[i]),
			.back_word  (sel_word[i])
		);
	end

	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			group_or[g] = '0;
			for (int j = 0; j < GROUP_CELLS; j++) begin
				if (g * GROUP_CELLS + j < CAPACITY) begin
					group_or[g] = group_or[g] | sel_word[g * GROUP_CELLS + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		group_s1 <= group_or;
	end

	always_comb begin
		back_word = '0;
		for (int g = 0; g < GROUPS; g++) begin
			back_word = back_word | group_s1[g];
		end
	end

	always_comb begin
		cmd        = '0;
		status_c   = STS_DONE;
		value_c    = '0;
		count_next = count_q;
		case (op_q)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_c = STS_FULL;
				end else begin
					cmd.shift_right = 1'b1;
					count_next      = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status_c = STS_FULL;
				end else begin
					cmd.push_back = 1'b1;
					count_next    = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_c = STS_EMPTY;
				end else begin
					status_c       = STS_DATA;
					value_c        = cell_word[0];
					cmd.shift_left = 1'b1;
					count_next     = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_c = STS_EMPTY;
				end else begin
					status_c     = STS_DATA;
					value_c      = back_word;
					cmd.pop_back = 1'b1;
					count_next   = count_q - CNT_W'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					status_c = STS_EMPTY;
				end else begin
					status_c = STS_DATA;
					value_c  = cell_word[0];
				end
			end
			OP_PEEK_BACK: begin
				if (empty) begin
					status_c = STS_EMPTY;
				end else begin
					status_c = STS_DATA;
					value_c  = back_word;
				end
			end
			OP_CLEAR: begin
				cmd.clear  = 1'b1;
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
		if (phase_q != PH_EXEC) begin
			cmd        = '0;
			count_next = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= (phase_q == PH_EXEC);
			count_q <= count_next;
			case (phase_q)
				PH_IDLE: begin
					if (accept) begin
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= request.operation;
			push_word_q <= WORD_BITS'(request.item_value);
		end
		if (phase_q == PH_EXEC) begin
			result_q.status       <= status_c;
			result_q.result_value <= 32'(value_c);
			result_q.occupancy    <= 7'(count_next);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// each taken item is followed by its done strobe
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result strobe missing after accepted item");

	// count agrees with the valid bits of the cell row
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == count_q)
		else $error("entry count differs from valid cells");

	// valid cells stay packed from cell 0
	assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + CAPACITY'(1)) & cell_valid) == '0)
		else $error("gap in the valid cell row");

	// a refused push leaves the count alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy && full && (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK))
		|=> count_q == $past(count_q))
		else $error("push on full queue changed the count");

endmodule
`default_nettype wire
